[hw/rtl/mfd_pkg.sv]
`timescale 1ns / 1ps

package mfd_pkg;

  // default sizes
  localparam int DELAY_DEPTH_DEF = 65536;
  localparam int SINE_BITS_DEF   = 10;

  // configuration port
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_ENABLE = 3'd5;

  // sample and arithmetic widths
  localparam int SMP_W   = 16;
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int WET_W   = 26;
  localparam int ACC_W   = 42;
  localparam int MAG_W   = 39;

  localparam logic [15:0] UNITY_Q15  = 16'd32768;
  localparam logic [14:0] FULL_SCALE = 15'd32767;

  // sine polynomial coefficients
  localparam logic [15:0] SIN_C1 = 16'd51472;
  localparam logic [14:0] SIN_C3 = 15'd21024;
  localparam logic [11:0] SIN_C5 = 12'd2320;

  // shared multiplier operations
  localparam int MUL_OP_W = 4;
  localparam logic [MUL_OP_W-1:0] MUL_HOLD = 4'd0;
  localparam logic [MUL_OP_W-1:0] MUL_UU   = 4'd1;
  localparam logic [MUL_OP_W-1:0] MUL_UC   = 4'd2;
  localparam logic [MUL_OP_W-1:0] MUL_UT   = 4'd3;
  localparam logic [MUL_OP_W-1:0] MUL_US   = 4'd4;
  localparam logic [MUL_OP_W-1:0] MUL_SM   = 4'd5;
  localparam logic [MUL_OP_W-1:0] MUL_LERP = 4'd6;
  localparam logic [MUL_OP_W-1:0] MUL_DRY  = 4'd7;
  localparam logic [MUL_OP_W-1:0] MUL_FB   = 4'd8;
  localparam logic [MUL_OP_W-1:0] MUL_MIX  = 4'd9;

  typedef struct packed {
    logic                load_in;
    logic [MUL_OP_W-1:0] mul_op;
    logic                cap_u2;
    logic                cap_d;
    logic                cap_raw;
    logic                cap_pos;
    logic                rd_en;
    logic                rd_sel;
    logic                cap_y0;
    logic                cap_wet;
    logic                cap_dry;
    logic                cap_acc_w;
    logic                cap_acc_y;
    logic                sat_load;
    logic                sat_sel;
    logic                mem_we;
    logic                out_load;
  } mfd_cmd_t;

  typedef struct packed {
    logic out_free;
  } mfd_sts_t;

endpackage

[hw/rtl/mfd_ram.sv]
`timescale 1ns / 1ps

module mfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/mfd_ctrl.sv]
`timescale 1ns / 1ps

module mfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfd_pkg::mfd_sts_t sts,
  output mfd_pkg::mfd_cmd_t cmd
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_UU   = 5'd1;
  localparam logic [4:0] ST_UC   = 5'd2;
  localparam logic [4:0] ST_UT   = 5'd3;
  localparam logic [4:0] ST_US   = 5'd4;
  localparam logic [4:0] ST_SM   = 5'd5;
  localparam logic [4:0] ST_DLY  = 5'd6;
  localparam logic [4:0] ST_RAW  = 5'd7;
  localparam logic [4:0] ST_POS  = 5'd8;
  localparam logic [4:0] ST_RD0  = 5'd9;
  localparam logic [4:0] ST_RD1  = 5'd10;
  localparam logic [4:0] ST_LERP = 5'd11;
  localparam logic [4:0] ST_WET  = 5'd12;
  localparam logic [4:0] ST_DRY  = 5'd13;
  localparam logic [4:0] ST_FB   = 5'd14;
  localparam logic [4:0] ST_MIX  = 5'd15;
  localparam logic [4:0] ST_SATW = 5'd16;
  localparam logic [4:0] ST_WR   = 5'd17;
  localparam logic [4:0] ST_OUT  = 5'd18;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_UU;
        end
      end
      ST_UU: begin
        cmd.mul_op = mfd_pkg::MUL_UU;
        state_nxt  = ST_UC;
      end
      ST_UC: begin
        cmd.cap_u2 = 1'b1;
        cmd.mul_op = mfd_pkg::MUL_UC;
        state_nxt  = ST_UT;
      end
      ST_UT: begin
        cmd.mul_op = mfd_pkg::MUL_UT;
        state_nxt  = ST_US;
      end
      ST_US: begin
        cmd.mul_op = mfd_pkg::MUL_US;
        state_nxt  = ST_SM;
      end
      ST_SM: begin
        cmd.mul_op = mfd_pkg::MUL_SM;
        state_nxt  = ST_DLY;
      end
      ST_DLY: begin
        cmd.cap_d = 1'b1;
        state_nxt = ST_RAW;
      end
      ST_RAW: begin
        cmd.cap_raw = 1'b1;
        state_nxt   = ST_POS;
      end
      ST_POS: begin
        cmd.cap_pos = 1'b1;
        state_nxt   = ST_RD0;
      end
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 1'b0;
        state_nxt  = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 1'b1;
        cmd.cap_y0 = 1'b1;
        state_nxt  = ST_LERP;
      end
      ST_LERP: begin
        cmd.mul_op = mfd_pkg::MUL_LERP;
        state_nxt  = ST_WET;
      end
      ST_WET: begin
        cmd.cap_wet = 1'b1;
        state_nxt   = ST_DRY;
      end
      ST_DRY: begin
        cmd.mul_op = mfd_pkg::MUL_DRY;
        state_nxt  = ST_FB;
      end
      ST_FB: begin
        cmd.cap_dry = 1'b1;
        cmd.mul_op  = mfd_pkg::MUL_FB;
        state_nxt   = ST_MIX;
      end
      ST_MIX: begin
        cmd.cap_acc_w = 1'b1;
        cmd.mul_op    = mfd_pkg::MUL_MIX;
        state_nxt     = ST_SATW;
      end
      ST_SATW: begin
        cmd.cap_acc_y = 1'b1;
        cmd.sat_load  = 1'b1;
        cmd.sat_sel   = 1'b0;
        state_nxt     = ST_WR;
      end
      ST_WR: begin
        cmd.mem_we   = 1'b1;
        cmd.sat_load = 1'b1;
        cmd.sat_sel  = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/mfd_dpath.sv]
`timescale 1ns / 1ps

module mfd_dpath #(
  parameter int DELAY_DEPTH     = mfd_pkg::DELAY_DEPTH_DEF,
  parameter int SINE_TABLE_BITS = mfd_pkg::SINE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfd_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic signed [mfd_pkg::SMP_W-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [mfd_pkg::SMP_W-1:0] out_sample,
  input  mfd_pkg::mfd_cmd_t              cmd,
  output mfd_pkg::mfd_sts_t              sts
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int PW = AW + 8;
  localparam int SB = SINE_TABLE_BITS;
  localparam int SH = 17 - SINE_TABLE_BITS;

  localparam logic [PW:0]   SPAN = (PW+1)'(DELAY_DEPTH * 256);
  localparam logic [PW-1:0] MAXD = PW'((DELAY_DEPTH - 2) * 256);
  localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [SB-1:0] HALF = SB'(1 << (SB - 1));
  localparam logic [mfd_pkg::MAG_W-1:0] ONE_Q38 = {1'b1, {(mfd_pkg::MAG_W-1){1'b0}}};

  // configuration registers
  logic [15:0] base_delay_r;
  logic [16:0] mod_depth_r;
  logic [15:0] feedback_gain_r;
  logic [15:0] wet_mix_r;
  logic [18:0] lfo_step_r;
  logic        effect_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_delay_r    <= '0;
      mod_depth_r     <= '0;
      feedback_gain_r <= '0;
      wet_mix_r       <= '0;
      lfo_step_r      <= '0;
      effect_enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        mfd_pkg::CFG_BASE_DELAY:    base_delay_r    <= cfg_wdata[15:0];
        mfd_pkg::CFG_MOD_DEPTH:     mod_depth_r     <= cfg_wdata[16:0];
        mfd_pkg::CFG_FEEDBACK_GAIN: feedback_gain_r <= cfg_wdata[15:0];
        mfd_pkg::CFG_WET_MIX:       wet_mix_r       <= cfg_wdata[15:0];
        mfd_pkg::CFG_LFO_STEP:      lfo_step_r      <= cfg_wdata[18:0];
        mfd_pkg::CFG_EFFECT_ENABLE: effect_enable_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  logic [15:0] fb;
  logic [15:0] mix;
  logic [15:0] dry_gain;

  assign fb       = (feedback_gain_r > mfd_pkg::UNITY_Q15) ? mfd_pkg::UNITY_Q15 : feedback_gain_r;
  assign mix      = !effect_enable_r ? 16'd0 :
                    (wet_mix_r > mfd_pkg::UNITY_Q15) ? mfd_pkg::UNITY_Q15 : wet_mix_r;
  assign dry_gain = mfd_pkg::UNITY_Q15 - mix;

  // control state
  logic [AW-1:0] wp_r;
  logic          wrapped_r;
  logic [31:0]   phase_r;
  logic          out_valid_r;

  // payload registers
  logic signed [15:0]               x_r;
  logic signed [mfd_pkg::MUL_P_W-1:0] mul_r;
  logic [15:0]                      u2_r;
  logic [PW-1:0]                    d_r;
  logic [PW:0]                      raw_r;
  logic [PW-1:0]                    pos_r;
  logic signed [15:0]               y0_r;
  logic signed [mfd_pkg::WET_W-1:0] wet_r;
  logic signed [31:0]               dry_r;
  logic signed [mfd_pkg::ACC_W-1:0] acc_w_r;
  logic signed [mfd_pkg::ACC_W-1:0] acc_y_r;
  logic [mfd_pkg::MAG_W-1:0]        satmag_r;
  logic                             satneg_r;
  logic signed [15:0]               out_sample_r;

  // quarter-wave fold of the lfo phase
  logic [SB-2:0] h;
  logic [SB-1:0] p_full;
  logic [SB-2:0] p;
  logic [15:0]   u;
  logic          sine_neg;

  assign h        = phase_r[30 -: (SB - 1)];
  assign p_full   = HALF - {1'b0, h};
  assign p        = h[SB-2] ? p_full[SB-2:0] : h;
  assign u        = {p, {SH{1'b0}}};
  assign sine_neg = phase_r[31];

  // polynomial terms taken from the multiplier register
  logic [15:0] u2_cur;
  logic [14:0] t;
  logic [15:0] t2;
  logic [15:0] s_raw;
  logic [14:0] s;
  logic [16:0] mod_mag;

  assign u2_cur  = mul_r[30:15];
  assign t       = mfd_pkg::SIN_C3 - {3'b0, mul_r[26:15]};
  assign t2      = mfd_pkg::SIN_C1 - {1'b0, mul_r[29:15]};
  assign s_raw   = mul_r[30:15];
  assign s       = (s_raw > {1'b0, mfd_pkg::FULL_SCALE}) ? mfd_pkg::FULL_SCALE : s_raw[14:0];
  assign mod_mag = mul_r[31:15];

  // read side
  logic [AW-1:0] r0;
  logic [AW-1:0] r1;
  logic [7:0]    frac;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic          valid0;
  logic          valid1;
  logic signed [15:0] y1;
  logic signed [16:0] diff;

  assign r0      = pos_r[PW-1:8];
  assign frac    = pos_r[7:0];
  assign r1      = (r0 == LAST) ? '0 : r0 + AW'(1);
  assign rd_addr = cmd.rd_sel ? r1 : r0;
  assign valid0  = wrapped_r || (r0 < wp_r);
  assign valid1  = wrapped_r || (r1 < wp_r);
  assign y1      = valid1 ? $signed(rd_data) : 16'sd0;
  assign diff    = {y1[15], y1} - {y0_r[15], y0_r};

  // shared multiplier
  logic signed [mfd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mfd_pkg::MUL_B_W-1:0] mul_b;
  logic                               mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.mul_op)
      mfd_pkg::MUL_UU: begin
        mul_a = {11'b0, u};
        mul_b = {2'b0, u};
      end
      mfd_pkg::MUL_UC: begin
        mul_a = {11'b0, u2_cur};
        mul_b = {6'b0, mfd_pkg::SIN_C5};
      end
      mfd_pkg::MUL_UT: begin
        mul_a = {11'b0, u2_r};
        mul_b = {3'b0, t};
      end
      mfd_pkg::MUL_US: begin
        mul_a = {11'b0, u};
        mul_b = {2'b0, t2};
      end
      mfd_pkg::MUL_SM: begin
        mul_a = {10'b0, mod_depth_r};
        mul_b = {3'b0, s};
      end
      mfd_pkg::MUL_LERP: begin
        mul_a = {{10{diff[16]}}, diff};
        mul_b = {10'b0, frac};
      end
      mfd_pkg::MUL_DRY: begin
        mul_a = {{11{x_r[15]}}, x_r};
        mul_b = {2'b0, dry_gain};
      end
      mfd_pkg::MUL_FB: begin
        mul_a = {wet_r[25], wet_r};
        mul_b = {2'b0, fb};
      end
      mfd_pkg::MUL_MIX: begin
        mul_a = {wet_r[25], wet_r};
        mul_b = {2'b0, mix};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // delay in 1/256 samples, clamped
  logic signed [26:0] mod_s;
  logic signed [26:0] d_val;
  logic [PW-1:0]      d_nxt;

  assign mod_s = sine_neg ? -$signed({10'b0, mod_mag}) : $signed({10'b0, mod_mag});
  assign d_val = $signed({3'b0, base_delay_r, 8'b0}) + mod_s;

  always_comb begin
    if (d_val[26]) begin
      d_nxt = '0;
    end else if (d_val[25:0] > 26'(MAXD)) begin
      d_nxt = MAXD;
    end else begin
      d_nxt = d_val[PW-1:0];
    end
  end

  logic [PW:0]   raw_nxt;
  logic [PW:0]   pos_sub;
  logic [PW-1:0] pos_nxt;

  assign raw_nxt = {1'b0, wp_r, 8'b0} + SPAN - {1'b0, d_r};
  assign pos_sub = raw_r - SPAN;
  assign pos_nxt = (raw_r >= SPAN) ? pos_sub[PW-1:0] : raw_r[PW-1:0];

  logic signed [mfd_pkg::WET_W-1:0] wet_nxt;
  logic signed [mfd_pkg::ACC_W-1:0] acc_w_nxt;
  logic signed [mfd_pkg::ACC_W-1:0] acc_y_nxt;

  assign wet_nxt   = {{2{y0_r[15]}}, y0_r, 8'b0} + mul_r[25:0];
  assign acc_w_nxt = {{3{x_r[15]}}, x_r, 23'b0} + mul_r[41:0];
  assign acc_y_nxt = {{2{dry_r[31]}}, dry_r, 8'b0} + mul_r[41:0];

  // saturation to +-1 and scaling by full scale, truncating toward zero
  logic signed [mfd_pkg::ACC_W-1:0] sat_in;
  logic [mfd_pkg::ACC_W-1:0]        sat_abs;
  logic [mfd_pkg::MAG_W-1:0]        satmag_nxt;
  logic [mfd_pkg::MAG_W+14:0]       scaled;
  logic [15:0]                      sat_res;
  logic [15:0]                      sat_val;

  assign sat_in     = cmd.sat_sel ? acc_y_r : acc_w_r;
  assign sat_abs    = sat_in[mfd_pkg::ACC_W-1] ? -sat_in : sat_in;
  assign satmag_nxt = (sat_abs > mfd_pkg::ACC_W'(ONE_Q38)) ? ONE_Q38
                                                           : sat_abs[mfd_pkg::MAG_W-1:0];
  assign scaled     = {satmag_r, 15'b0} - {15'b0, satmag_r};
  assign sat_res    = scaled[mfd_pkg::MAG_W+14 -: 16];
  assign sat_val    = satneg_r ? -sat_res : sat_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        phase_r <= phase_r + {13'b0, lfo_step_r};
      end
      if (cmd.mem_we) begin
        if (wp_r == LAST) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= in_sample;
    end
    if (mul_en) begin
      mul_r <= mul_a * mul_b;
    end
    if (cmd.cap_u2) begin
      u2_r <= u2_cur;
    end
    if (cmd.cap_d) begin
      d_r <= d_nxt;
    end
    if (cmd.cap_raw) begin
      raw_r <= raw_nxt;
    end
    if (cmd.cap_pos) begin
      pos_r <= pos_nxt;
    end
    if (cmd.cap_y0) begin
      y0_r <= valid0 ? $signed(rd_data) : 16'sd0;
    end
    if (cmd.cap_wet) begin
      wet_r <= wet_nxt;
    end
    if (cmd.cap_dry) begin
      dry_r <= mul_r[31:0];
    end
    if (cmd.cap_acc_w) begin
      acc_w_r <= acc_w_nxt;
    end
    if (cmd.cap_acc_y) begin
      acc_y_r <= acc_y_nxt;
    end
    if (cmd.sat_load) begin
      satmag_r <= satmag_nxt;
      satneg_r <= sat_in[mfd_pkg::ACC_W-1];
    end
    if (cmd.out_load) begin
      out_sample_r <= sat_val;
    end
  end

  mfd_ram #(
    .WIDTH(mfd_pkg::SMP_W),
    .DEPTH(DELAY_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.mem_we),
    .waddr(wp_r),
    .wdata(sat_val),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;

  // write pointer moves only with a store write
  a_wp_moves_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.mem_we |=> $stable(wp_r))
    else $error("write pointer moved without a store write");

  // a new result never overwrites one still waiting
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a stalled result");

  // clamped delay stays inside the line
  a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_d |=> (d_r <= MAXD))
    else $error("delay beyond line length");

  // wrapped read position stays inside the line
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_pos |=> ({1'b0, pos_r} < SPAN))
    else $error("read position out of range");

endmodule

[hw/rtl/modulated_feedback_delay_unit.sv]
`timescale 1ns / 1ps

// modulated delay line with feedback and dry/wet mix
// config: write cfg_wdata to register cfg_index when cfg_we is high, only while
//   the block is idle; registers are base_delay, mod_depth, feedback_gain,
//   wet_mix, lfo_step and effect_enable in index order
// input: one signed sample per transfer (in_valid high, in_stall low); in_stall
//   stays high while an item is being worked on
// output: one mixed sample per input, held in an output register until the
//   transfer completes (out_valid high, out_stall low)
// out_valid rises when the output state loads the finished result
// items are taken one at a time: the sequence of 9 passes through the shared 27x18
//   multiplier, two reads through the one read port of the delay memory and one
//   write to it completes before the next input transfer is accepted
// a stalled receiver holds one finished result; the block then finishes the
//   next item and waits for the output register before accepting a third
// reset: registers return to defaults, pointer and lfo phase go to zero; delay
//   entries not yet written since reset read as zero, so no clearing pass is
//   needed and an item may be accepted in the first cycle after reset

module modulated_feedback_delay_unit #(
  parameter int DELAY_DEPTH     = mfd_pkg::DELAY_DEPTH_DEF,
  parameter int SINE_TABLE_BITS = mfd_pkg::SINE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mfd_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [mfd_pkg::SMP_W-1:0] in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mfd_pkg::SMP_W-1:0] out_sample
);

  mfd_pkg::mfd_cmd_t cmd;
  mfd_pkg::mfd_sts_t sts;

  mfd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  mfd_dpath #(
    .DELAY_DEPTH    (DELAY_DEPTH),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_sample(out_sample),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
